/* src/rlr_pkg.sv */
// Shared types and constants for the regression loss reducer.
// Used by rlr_mul, rlr_div, rlr_datapath, rlr_ctrl and the top level.
package rlr_pkg;

	localparam int ValW     = 64;   // loss, sum and quotient width
	localparam int MulCntW  = 7;    // holds ValW steps
	localparam int DivW     = 32;   // divisor width
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	localparam int ThrW     = 31;
	localparam int InvW     = 32;
	localparam int BatchW   = 24;
	localparam int KindW    = 2;

	localparam logic [ValW-1:0] PosMax = {1'b0, {(ValW-1){1'b1}}};

	// loss kinds
	localparam logic [KindW-1:0] KIND_L1  = 2'd0;
	localparam logic [KindW-1:0] KIND_SQ  = 2'd1;
	localparam logic [KindW-1:0] KIND_HUB = 2'd2;
	localparam logic [KindW-1:0] KIND_SL1 = 2'd3;

	// reduction modes
	localparam logic [KindW-1:0] RED_NONE  = 2'd0;
	localparam logic [KindW-1:0] RED_SUM   = 2'd1;
	localparam logic [KindW-1:0] RED_MEAN  = 2'd2;
	localparam logic [KindW-1:0] RED_BATCH = 2'd3;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_KIND   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RED    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_THR    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_INV    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BATCH  = 3'd4;

	typedef enum logic [1:0] {
		MSEL_SQ,    // |d| * |d|
		MSEL_HUB,   // T * (2|d| - T)
		MSEL_INV    // previous product * inv_two_beta
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_DECIDE,
		ST_MUL_A,
		ST_MUL_B,
		ST_POST,
		ST_REDUCE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     abs_load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     loss_load;
		logic     acc_update;
		logic     div_start;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic             mul_done;
		logic             div_done;
		logic             below;
		logic             last;
		logic             div_zero;
		logic [KindW-1:0] kind;
		logic [KindW-1:0] mode;
	} stat_t;

endpackage

/* src/rlr_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, 64 by 64 bits.
// Depends on rlr_pkg.
module rlr_mul
	import rlr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ValW-1:0]   a,
	input  logic [ValW-1:0]   b,
	output logic [2*ValW-1:0] prod,
	output logic              done
);

	logic [ValW-1:0]    a_q;
	logic [2*ValW-1:0]  p_q;
	logic [MulCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ValW:0]      sum;

	// add multiplicand when the low bit is set
	assign sum = p_q[0] ? ({1'b0, p_q[2*ValW-1:ValW]} + {1'b0, a_q})
	                    : {1'b0, p_q[2*ValW-1:ValW]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= MulCntW'(ValW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MulCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// product register shifts right each step
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{ValW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[ValW-1:1]};
		end
	end

	assign prod = p_q;
	assign done = done_q;

endmodule

/* src/rlr_div.sv */
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on rlr_pkg.
module rlr_div
	import rlr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [ValW-1:0] dividend,
	input  logic [DivW-1:0] divisor,
	output logic [ValW-1:0] quotient,
	output logic            done
);

	logic [ValW-1:0]    quo_q;
	logic [DivW-1:0]    rem_q;
	logic [DivW-1:0]    dv_q;
	logic [MulCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivW:0]      sh;
	logic [DivW:0]      diff;
	logic               fits;

	assign sh   = {rem_q, quo_q[ValW-1]};
	assign fits = (sh >= {1'b0, dv_q});
	assign diff = sh - {1'b0, dv_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= MulCntW'(ValW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MulCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DivW-1:0] : sh[DivW-1:0];
			quo_q <= {quo_q[ValW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* src/rlr_datapath.sv */
// Datapath: config registers, difference and loss forming, sum, count, output register.
// Depends on rlr_pkg, rlr_mul and rlr_div.
module rlr_datapath
	import rlr_pkg::*;
#(
	parameter int DATA_WIDTH  = 32,
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [CfgDataW-1:0]   cfg_data,
	input  logic [2*DATA_WIDTH-1:0] in_pair,
	input  logic                  in_last,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic [ValW-1:0]       loss_value,
	output logic                  is_reduced,
	output logic                  overflowed
);

	logic [KindW-1:0]       kind_q;
	logic [KindW-1:0]       mode_q;
	logic [ThrW-1:0]        thr_q;
	logic [InvW-1:0]        inv_q;
	logic [BatchW-1:0]      batch_q;

	logic [ValW-1:0]        d_q;
	logic [ValW-1:0]        ad_q;
	logic                   last_q;
	logic [ValW-1:0]        loss_q;
	logic                   flag_q;
	logic [ValW-1:0]        acc_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   sat_q;
	logic [ValW-1:0]        out_val_q;
	logic                   out_red_q;
	logic                   out_ovf_q;

	logic [ValW-1:0]        pred_x;
	logic [ValW-1:0]        targ_x;
	logic [ValW-1:0]        thr_x;
	logic [ValW-1:0]        two_ad_t;
	logic [ValW-1:0]        mul_a;
	logic [ValW-1:0]        mul_b;
	logic [2*ValW-1:0]      prod;
	logic                   mul_done;
	logic [2*ValW-1:0]      prod_sh;
	logic [ValW-1:0]        loss_next;
	logic                   flag_next;
	logic [ValW:0]          acc_sum;
	logic                   acc_ovf;
	logic [DivW-1:0]        divisor;
	logic [ValW-1:0]        quotient;
	logic                   div_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_L1;
			mode_q  <= RED_MEAN;
			thr_q   <= ThrW'(65536);
			inv_q   <= InvW'(32768);
			batch_q <= BatchW'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KIND:  kind_q  <= cfg_data[KindW-1:0];
				REG_RED:   mode_q  <= cfg_data[KindW-1:0];
				REG_THR:   thr_q   <= cfg_data[ThrW-1:0];
				REG_INV:   inv_q   <= cfg_data[InvW-1:0];
				REG_BATCH: batch_q <= cfg_data[BatchW-1:0];
				default: ;
			endcase
		end
	end

	// sign-extended operands and zero-extended threshold
	assign pred_x = {{(ValW-DATA_WIDTH){in_pair[DATA_WIDTH-1]}}, in_pair[DATA_WIDTH-1:0]};
	assign targ_x = {{(ValW-DATA_WIDTH){in_pair[2*DATA_WIDTH-1]}},
	                 in_pair[2*DATA_WIDTH-1:DATA_WIDTH]};
	assign thr_x  = {{(ValW-ThrW){1'b0}}, thr_q};
	assign two_ad_t = {ad_q[ValW-2:0], 1'b0} - thr_x;

	// difference, then magnitude
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			d_q    <= pred_x - targ_x;
			last_q <= in_last;
		end
		if (cmd.abs_load) begin
			ad_q <= d_q[ValW-1] ? (~d_q + 1'b1) : d_q;
		end
	end

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MSEL_SQ: begin
				mul_a = ad_q;
				mul_b = ad_q;
			end
			MSEL_HUB: begin
				mul_a = thr_x;
				mul_b = two_ad_t;
			end
			MSEL_INV: begin
				mul_a = prod[ValW-1:0];
				mul_b = {{(ValW-InvW){1'b0}}, inv_q};
			end
			default: begin
				mul_a = ad_q;
				mul_b = ad_q;
			end
		endcase
	end

	rlr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	// product scaling by kind
	always_comb begin
		case (kind_q)
			KIND_SQ:  prod_sh = prod >> FRAC_BITS;
			KIND_HUB: prod_sh = prod >> (FRAC_BITS + 1);
			default:  prod_sh = prod >> (2 * FRAC_BITS);
		endcase
	end

	// element loss select with saturation
	always_comb begin
		loss_next = '0;
		flag_next = 1'b0;
		if (kind_q == KIND_L1) begin
			loss_next = ad_q;
		end else if (kind_q == KIND_SL1 && !stat.below) begin
			loss_next = {1'b0, two_ad_t[ValW-1:1]};
		end else if (|prod_sh[2*ValW-1:ValW-1]) begin
			loss_next = PosMax;
			flag_next = 1'b1;
		end else begin
			loss_next = prod_sh[ValW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.loss_load) begin
			loss_q <= loss_next;
			flag_q <= flag_next;
		end
	end

	// saturating sum
	assign acc_sum = {1'b0, acc_q} + {1'b0, loss_q};
	assign acc_ovf = (acc_sum > {1'b0, PosMax});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.out_load && mode_q != RED_NONE) begin
			acc_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.acc_update) begin
			acc_q <= acc_ovf ? PosMax : acc_sum[ValW-1:0];
			if (cnt_q != {COUNT_WIDTH{1'b1}}) begin
				cnt_q <= cnt_q + 1'b1;
			end
			sat_q <= sat_q | flag_q | acc_ovf;
		end
	end

	// divisor: count for mean, batch size otherwise
	assign divisor = (mode_q == RED_MEAN) ? DivW'(cnt_q) : DivW'(batch_q);

	rlr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (mode_q == RED_NONE) begin
				out_val_q <= loss_q;
				out_red_q <= 1'b0;
				out_ovf_q <= flag_q;
			end else begin
				out_val_q <= (mode_q == RED_SUM || divisor == '0) ? acc_q : quotient;
				out_red_q <= 1'b1;
				out_ovf_q <= sat_q;
			end
		end
	end

	assign loss_value = out_val_q;
	assign is_reduced = out_red_q;
	assign overflowed = out_ovf_q;

	// status to controller
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.below    = (ad_q < thr_x);
	assign stat.last     = last_q;
	assign stat.div_zero = (divisor == '0);
	assign stat.kind     = kind_q;
	assign stat.mode     = mode_q;

endmodule

/* src/rlr_ctrl.sv */
// Controller state machine: sequences each item through the datapath.
// Depends on rlr_pkg.
module rlr_ctrl
	import rlr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_ABS;
			ST_ABS:    state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (stat.kind == KIND_L1 || (stat.kind == KIND_SL1 && !stat.below)) begin
					state_d = ST_POST;
				end else begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				if (stat.mul_done) begin
					state_d = (stat.kind == KIND_SL1) ? ST_MUL_B : ST_POST;
				end
			end
			ST_MUL_B:  if (stat.mul_done) state_d = ST_POST;
			ST_POST: begin
				if (stat.mode == RED_NONE) begin
					state_d = ST_EMIT;
				end else begin
					state_d = stat.last ? ST_REDUCE : ST_IDLE;
				end
			end
			ST_REDUCE: begin
				if (stat.mode == RED_SUM || stat.div_zero) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV:    if (stat.div_done) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MSEL_SQ;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ABS:    cmd.abs_load = 1'b1;
			ST_DECIDE: begin
				if (stat.kind == KIND_L1 || (stat.kind == KIND_SL1 && !stat.below)) begin
					cmd.loss_load = 1'b1;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = (stat.kind == KIND_HUB && !stat.below) ? MSEL_HUB
					                                                       : MSEL_SQ;
				end
			end
			ST_MUL_A: begin
				if (stat.mul_done) begin
					if (stat.kind == KIND_SL1) begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = MSEL_INV;
					end else begin
						cmd.loss_load = 1'b1;
					end
				end
			end
			ST_MUL_B:  cmd.loss_load  = stat.mul_done;
			ST_POST:   cmd.acc_update = (stat.mode != RED_NONE);
			ST_REDUCE: cmd.div_start  = !(stat.mode == RED_SUM || stat.div_zero);
			ST_DIV:    ;
			ST_EMIT:   cmd.out_load   = out_free;
			default:   ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* src/regression_loss_reducer.sv */
// Regression loss reducer (L1, squared error, Huber, smooth L1) with sum, mean or batch reduction.
// Top level: joins rlr_ctrl and rlr_datapath. Depends on rlr_pkg.
//
// Usage: prediction/target pairs enter on the s_ channel, one item per handshake,
// s_tlast marking the last element of a tensor. Results leave on the m_ channel.
// With no reduction each element gives one result; otherwise only the last element
// of a tensor gives one, the reduced sum, mean over elements or sum over batch size.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Per item, L1 and large-error smooth L1 skip the bit-serial multiplier, squared error
// and Huber use one product and small-error smooth L1 two (the square, then the
// scaling by inv_two_beta). With no reduction the output register load adds a state.
// A tensor end adds the reduce and emit states, plus mean or batch division in the
// bit-serial divider; the result then goes to the output register.
// The output register holds one result; the next item is taken while it waits, and
// the block stalls only when a new result is ready, one still waits and m_tready is low.
// Reset clears the sum, count and overflow flag and loads register defaults.
module regression_loss_reducer
	import rlr_pkg::*;
#(
	parameter int DATA_WIDTH  = 32,
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [CfgIdxW-1:0]                  cfg_index,
	input  logic [CfgDataW-1:0]                 cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// prediction, target_value (low bit up), zero padded to bytes
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
	input  logic                                s_tlast,   // final_element
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ValW-1:0]                     m_tdata,   // loss_value
	output logic [1:0]                          m_tuser    // is_reduced, overflowed
);

	cmd_t  cmd;
	stat_t stat;
	logic  is_reduced;
	logic  overflowed;

	rlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rlr_datapath #(
		.DATA_WIDTH  (DATA_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_pair    (s_tdata[2*DATA_WIDTH-1:0]),
		.in_last    (s_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.loss_value (m_tdata),
		.is_reduced (is_reduced),
		.overflowed (overflowed)
	);

	assign m_tuser = {overflowed, is_reduced};

endmodule
